[hdl/assert_macros.svh]
// Assertion macros shared by the mixer's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RCVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RCVM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rcvm_pkg.sv]
// Shared types and constants of the random chirp voice mixer.
package rcvm_pkg;

  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FRAMES_W   = 13;
  localparam int unsigned RND_W      = 15;
  localparam int unsigned RATE_W     = 24;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;

  // 32767 = 2^15 - 1, applied as a shift and a subtract
  localparam int unsigned GAIN_SHIFT = 15;
  // Trigger threshold is clamped to this value
  localparam logic [RND_W-1:0] THR_MAX = 15'd16383;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_PLAY = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHIRP_RATE   = 4'd0,
    REG_CHIRP_LENGTH = 4'd1
  } cfg_reg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic mul;
    logic sub;
    logic trig;
    logic clr_acc;
    logic issue;
    logic last;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic play;
  } sts_t;

endpackage

[hdl/rcvm_ifs.sv]
// Channel interfaces of the mixer: input items, results, register writes.
interface rcvm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [rcvm_pkg::ADDR_W-1:0]         load_address;
  logic signed [rcvm_pkg::SAMPLE_W-1:0] load_left;
  logic signed [rcvm_pkg::SAMPLE_W-1:0] load_right;
  logic                                interval_start;
  logic [rcvm_pkg::FRAMES_W-1:0]       interval_frames;
  logic [rcvm_pkg::RND_W-1:0]          random_value;

  modport source (
    output valid, func, load_address, load_left, load_right,
           interval_start, interval_frames, random_value,
    input  ready
  );
  modport sink (
    input  valid, func, load_address, load_left, load_right,
           interval_start, interval_frames, random_value,
    output ready
  );
endinterface

interface rcvm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rcvm_pkg::SAMPLE_W-1:0] out_left;
  logic signed [rcvm_pkg::SAMPLE_W-1:0] out_right;
  logic                                 clipped_left;
  logic                                 clipped_right;
  logic                                 chirp_started;

  modport source (
    output valid, out_left, out_right, clipped_left, clipped_right, chirp_started,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_right, clipped_left, clipped_right, chirp_started,
    output ready
  );
endinterface

interface rcvm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rcvm_pkg::CFG_IDX_W-1:0]     index;
  logic [rcvm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/rcvm_ctrl.sv]
// Sequencing state machine of the mixer.
`include "assert_macros.svh"

module rcvm_ctrl #(
  parameter int unsigned VOICES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rcvm_pkg::sts_t       sts_i,
  output rcvm_pkg::cmd_t       cmd_o,
  output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] vidx_o
);

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SUB,
    S_TRIG,
    S_MIX,
    S_DRAIN,
    S_OUT
  } state_e;

  state_e          state_q;
  logic [VW-1:0]   vidx_q;
  logic            out_valid_q;
  logic            last_voice;

  assign last_voice  = (vidx_q == VW'(VOICES - 1));
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign vidx_o      = vidx_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.load_wr  = (state_q == S_DECODE) && !sts_i.play;
    cmd_o.mul      = (state_q == S_DECODE) && sts_i.play;
    cmd_o.sub      = (state_q == S_SUB);
    cmd_o.trig     = (state_q == S_TRIG);
    cmd_o.clr_acc  = (state_q == S_TRIG);
    cmd_o.issue    = (state_q == S_MIX);
    cmd_o.last     = (state_q == S_MIX) && last_voice;
    cmd_o.out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DECODE;
        end
        S_DECODE: begin
          state_q <= sts_i.play ? S_SUB : S_IDLE;
        end
        S_SUB: begin
          state_q <= S_TRIG;
        end
        S_TRIG: begin
          vidx_q  <= '0;
          state_q <= S_MIX;
        end
        S_MIX: begin
          if (last_voice) begin
            state_q <= S_DRAIN;
          end else begin
            vidx_q <= vidx_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (cmd_o.out_load) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `RCVM_ASSERT_IMP(a_issue_in_range, cmd_o.issue, vidx_q <= VW'(VOICES - 1), "voice index out of range")
  `RCVM_ASSERT_IMP(a_no_accept_in_mix, cmd_o.issue, !in_ready_o, "input taken during mix pass")
  `RCVM_ASSERT_NXT(a_load_done, cmd_o.load_wr, state_q == S_IDLE, "load did not return to idle")

endmodule

[hdl/rcvm_dp.sv]
// Datapath of the mixer: registers, chirp store, trigger test, voices, mix.
`include "assert_macros.svh"

module rcvm_dp #(
  parameter int unsigned VOICES      = 8,
  parameter int unsigned CHIRP_DEPTH = 4096,
  parameter int unsigned SAMPLE_RATE = 44100
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rcvm_pkg::cmd_t                        cmd_i,
  input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] vidx_i,
  output rcvm_pkg::sts_t                        sts_o,
  input  logic                                  cfg_we_i,
  input  logic [rcvm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [rcvm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  func_i,
  input  logic [rcvm_pkg::ADDR_W-1:0]           load_address_i,
  input  logic signed [rcvm_pkg::SAMPLE_W-1:0]  load_left_i,
  input  logic signed [rcvm_pkg::SAMPLE_W-1:0]  load_right_i,
  input  logic                                  interval_start_i,
  input  logic [rcvm_pkg::FRAMES_W-1:0]         interval_frames_i,
  input  logic [rcvm_pkg::RND_W-1:0]            random_value_i,
  output logic signed [rcvm_pkg::SAMPLE_W-1:0]  out_left_o,
  output logic signed [rcvm_pkg::SAMPLE_W-1:0]  out_right_o,
  output logic                                  clipped_left_o,
  output logic                                  clipped_right_o,
  output logic                                  chirp_started_o
);

  localparam int unsigned VW      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned PW      = $clog2(CHIRP_DEPTH);
  localparam int unsigned LW      = $clog2(CHIRP_DEPTH + 1);
  localparam int unsigned EW      = LW + 1;
  localparam int unsigned SW      = rcvm_pkg::SAMPLE_W + $clog2(VOICES) + 1;
  localparam int unsigned DIVISOR = 256 * SAMPLE_RATE;
  localparam int unsigned DIV_W   = $clog2(DIVISOR + 1);
  localparam int unsigned PROD_W  = rcvm_pkg::RATE_W + rcvm_pkg::FRAMES_W;
  localparam int unsigned X_W     = PROD_W + rcvm_pkg::GAIN_SHIFT;
  localparam int unsigned RHS_W   = rcvm_pkg::RND_W + 1 + DIV_W;
  localparam int unsigned CMP_W   = (X_W > RHS_W) ? X_W : RHS_W;
  localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-32768);

  // Configuration registers
  logic [rcvm_pkg::RATE_W-1:0] rate_q;
  logic [rcvm_pkg::LEN_W-1:0]  len_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= '0;
      len_cfg_q <= rcvm_pkg::LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcvm_pkg::REG_CHIRP_RATE:   rate_q    <= cfg_data_i[rcvm_pkg::RATE_W-1:0];
        rcvm_pkg::REG_CHIRP_LENGTH: len_cfg_q <= cfg_data_i[rcvm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item
  logic                                 func_q;
  logic [rcvm_pkg::ADDR_W-1:0]          addr_q;
  logic signed [rcvm_pkg::SAMPLE_W-1:0] left_q;
  logic signed [rcvm_pkg::SAMPLE_W-1:0] right_q;
  logic                                 istart_q;
  logic [rcvm_pkg::FRAMES_W-1:0]        frames_q;
  logic [rcvm_pkg::RND_W-1:0]           rnd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      addr_q   <= load_address_i;
      left_q   <= load_left_i;
      right_q  <= load_right_i;
      istart_q <= interval_start_i;
      frames_q <= interval_frames_i;
      rnd_q    <= random_value_i;
    end
  end

  assign sts_o.play = (func_q == rcvm_pkg::FUNC_PLAY);

  // Trigger test: rnd < floor(X / D)  <=>  X >= (rnd + 1) * D
  logic [PROD_W-1:0] prod_q;
  logic [RHS_W-1:0]  rhs_q;
  logic [X_W-1:0]    x_q;
  logic              fire;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(rate_q) * PROD_W'(frames_q);
      rhs_q  <= RHS_W'({1'b0, rnd_q} + 16'd1) * RHS_W'(DIVISOR);
    end
    if (cmd_i.sub) begin
      x_q <= (X_W'(prod_q) << rcvm_pkg::GAIN_SHIFT) - X_W'(prod_q);
    end
  end

  assign fire = cmd_i.trig && istart_q && (rnd_q < rcvm_pkg::THR_MAX) &&
                (CMP_W'(x_q) >= CMP_W'(rhs_q));

  // Effective chirp length, 1..CHIRP_DEPTH
  logic [LW-1:0] len_eff;

  always_comb begin
    if (len_cfg_q == '0) begin
      len_eff = LW'(1);
    end else if (32'(len_cfg_q) > CHIRP_DEPTH) begin
      len_eff = LW'(CHIRP_DEPTH);
    end else begin
      len_eff = LW'(len_cfg_q);
    end
  end

  // Voice state
  logic [VOICES-1:0] active_q;
  logic [PW-1:0]     pos_q [VOICES];
  logic [VW-1:0]     pick_q;
  logic              found_q;
  logic [VW-1:0]     best_q;
  logic [PW-1:0]     best_pos_q;
  logic              hit_q;
  logic              started_q;

  logic              cur_act;
  logic [PW-1:0]     cur_pos;
  logic [PW:0]       pos_inc;
  logic              at_end;
  logic              new_act;
  logic [PW-1:0]     new_pos;
  logic              cand_found;
  logic [VW-1:0]     cand_best;
  logic [PW-1:0]     cand_bpos;

  assign cur_act = active_q[vidx_i];
  assign cur_pos = pos_q[vidx_i];
  assign pos_inc = {1'b0, cur_pos} + 1'b1;
  assign at_end  = (EW'(pos_inc) >= EW'(len_eff));
  assign new_act = cur_act && !at_end;
  assign new_pos = new_act ? pos_inc[PW-1:0] : '0;

  // Next frame's steal choice, tracked from the post-advance state
  always_comb begin
    logic first;
    first      = (vidx_i == '0);
    cand_found = first ? 1'b0 : found_q;
    cand_best  = first ? '0 : best_q;
    cand_bpos  = first ? '0 : best_pos_q;
    if (!cand_found) begin
      if (!new_act) begin
        cand_found = 1'b1;
        cand_best  = vidx_i;
      end else if (first || (new_pos > cand_bpos)) begin
        cand_best  = vidx_i;
        cand_bpos  = new_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= '0;
      for (int v = 0; v < VOICES; v++) pos_q[v] <= '0;
      pick_q     <= '0;
      found_q    <= 1'b0;
      best_q     <= '0;
      best_pos_q <= '0;
      hit_q      <= 1'b0;
      started_q  <= 1'b0;
    end else begin
      if (fire) begin
        active_q[pick_q] <= 1'b1;
        pos_q[pick_q]    <= '0;
      end
      if (cmd_i.issue) begin
        active_q[vidx_i] <= new_act;
        pos_q[vidx_i]    <= new_pos;
        found_q          <= cand_found;
        best_q           <= cand_best;
        best_pos_q       <= cand_bpos;
        if (cmd_i.last) pick_q <= cand_best;
      end
      hit_q <= cmd_i.issue && cur_act;
      if (cmd_i.trig) started_q <= fire;
    end
  end

  // Chirp store, left in the low half
  logic [2*rcvm_pkg::SAMPLE_W-1:0] store_q [CHIRP_DEPTH];
  logic [2*rcvm_pkg::SAMPLE_W-1:0] rd_data_q;
  logic [PW-1:0]                   wr_idx;
  logic                            addr_ok;

  assign wr_idx  = PW'(addr_q);
  assign addr_ok = (32'(addr_q) < CHIRP_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && addr_ok) begin
      store_q[wr_idx] <= {right_q, left_q};
    end
    if (cmd_i.issue) begin
      rd_data_q <= store_q[cur_pos];
    end
  end

  // Accumulate and saturate
  logic signed [rcvm_pkg::SAMPLE_W-1:0] rd_l;
  logic signed [rcvm_pkg::SAMPLE_W-1:0] rd_r;
  logic signed [SW-1:0]                 acc_l_q;
  logic signed [SW-1:0]                 acc_r_q;

  assign rd_l = $signed(rd_data_q[rcvm_pkg::SAMPLE_W-1:0]);
  assign rd_r = $signed(rd_data_q[2*rcvm_pkg::SAMPLE_W-1:rcvm_pkg::SAMPLE_W]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_acc) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (hit_q) begin
      acc_l_q <= acc_l_q + SW'(rd_l);
      acc_r_q <= acc_r_q + SW'(rd_r);
    end
  end

  logic hi_l, lo_l, hi_r, lo_r;

  assign hi_l = (acc_l_q > SAT_HI);
  assign lo_l = (acc_l_q < SAT_LO);
  assign hi_r = (acc_r_q > SAT_HI);
  assign lo_r = (acc_r_q < SAT_LO);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_left_o      <= hi_l ? SAT_HI[rcvm_pkg::SAMPLE_W-1:0] :
                         lo_l ? SAT_LO[rcvm_pkg::SAMPLE_W-1:0] :
                                acc_l_q[rcvm_pkg::SAMPLE_W-1:0];
      out_right_o     <= hi_r ? SAT_HI[rcvm_pkg::SAMPLE_W-1:0] :
                         lo_r ? SAT_LO[rcvm_pkg::SAMPLE_W-1:0] :
                                acc_r_q[rcvm_pkg::SAMPLE_W-1:0];
      clipped_left_o  <= hi_l || lo_l;
      clipped_right_o <= hi_r || lo_r;
      chirp_started_o <= started_q;
    end
  end

  `RCVM_ASSERT_IMP(a_hit_after_issue, hit_q, $past(cmd_i.issue), "stray accumulate")
  `RCVM_ASSERT_NXT(a_fire_starts_voice, fire, active_q[$past(pick_q)] && (pos_q[$past(pick_q)] == '0), "triggered voice not started")

endmodule

[hdl/random_chirp_voice_mixer.sv]
// Top level of the random chirp voice mixer.
//
//  channel | dir | port  | transfer carries
//  --------+-----+-------+-----------------------------------------------
//  input   | in  | in_i  | func, load frame, interval data, random value
//  result  | out | out_o | saturated stereo frame, clip flags, start flag
//  config  | in  | cfg_i | register index and write data
//
// Items are taken only in idle. A load goes through decode back to idle; a play
// then passes subtract, trigger, mix, drain and output, the mix pass visiting one
// voice a cycle through the single read port of the chirp store.
// Reset (rst_ni, async, active low) idles all voices and the controller; the
// chirp store is not cleared. A stalled result waits in the output register
// while the next item is already taken in; only a second play result stalls.
// Config writes are always taken (ready tied high).

module random_chirp_voice_mixer #(
  parameter int unsigned VOICES      = 8,
  parameter int unsigned CHIRP_DEPTH = 4096,
  parameter int unsigned SAMPLE_RATE = 44100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcvm_in_if.sink     in_i,
  rcvm_out_if.source  out_o,
  rcvm_cfg_if.sink    cfg_i
);

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  rcvm_pkg::cmd_t cmd;
  rcvm_pkg::sts_t sts;
  logic [VW-1:0]  vidx;

  // Register writes never stall
  assign cfg_i.ready = 1'b1;

  rcvm_ctrl #(
    .VOICES (VOICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .vidx_o      (vidx)
  );

  // Trigger test, voice table, chirp store and mix accumulators
  rcvm_dp #(
    .VOICES      (VOICES),
    .CHIRP_DEPTH (CHIRP_DEPTH),
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .vidx_i            (vidx),
    .sts_o             (sts),
    .cfg_we_i          (cfg_i.valid),
    .cfg_idx_i         (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .func_i            (in_i.func),
    .load_address_i    (in_i.load_address),
    .load_left_i       (in_i.load_left),
    .load_right_i      (in_i.load_right),
    .interval_start_i  (in_i.interval_start),
    .interval_frames_i (in_i.interval_frames),
    .random_value_i    (in_i.random_value),
    .out_left_o        (out_o.out_left),
    .out_right_o       (out_o.out_right),
    .clipped_left_o    (out_o.clipped_left),
    .clipped_right_o   (out_o.clipped_right),
    .chirp_started_o   (out_o.chirp_started)
  );

endmodule

[bench/tb_random_chirp_voice_mixer.sv]
// Self-checking bench for the random chirp voice mixer: predicted frames vs. DUT output.
`timescale 1ns / 100ps

module tb_random_chirp_voice_mixer;

  // Block parameters, mirrored here so the predictor runs at the same sizes
  localparam int unsigned VOICES      = 8;
  localparam int unsigned CHIRP_DEPTH = 4096;
  localparam int unsigned SAMPLE_RATE = 44100;

  // Field widths taken from the shared package
  localparam int unsigned ADDR_W     = rcvm_pkg::ADDR_W;
  localparam int unsigned SAMPLE_W   = rcvm_pkg::SAMPLE_W;
  localparam int unsigned FRAMES_W   = rcvm_pkg::FRAMES_W;
  localparam int unsigned RND_W      = rcvm_pkg::RND_W;
  localparam int unsigned RATE_W     = rcvm_pkg::RATE_W;
  localparam int unsigned LEN_W      = rcvm_pkg::LEN_W;
  localparam int unsigned CFG_IDX_W  = rcvm_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = rcvm_pkg::CFG_DATA_W;
  localparam logic [RND_W-1:0] THR_MAX = rcvm_pkg::THR_MAX;

  // Probability scale: threshold is rate * frames * 32767 / (256 * fs)
  localparam longint unsigned PROB_SCALE = 32767;
  localparam longint unsigned RATE_UNIT  = 256;

  localparam int unsigned FILL_DEPTH   = 320;   // store entries preloaded before play
  localparam int unsigned NUM_PHASES   = 9;
  localparam int unsigned PHASE_ITEMS  = 134;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned TAIL_CYCLES  = 50;
  localparam int unsigned LONG_HOLD    = 400;   // receiver back-pressure burst
  localparam int unsigned HOLD_PHASE   = 6;
  localparam int unsigned PAUSE_PHASE  = 7;
  localparam int unsigned SPARE_PHASE  = 4;     // an unmapped register is poked here
  localparam int unsigned JUNK_PHASE   = 5;     // length written with garbage upper bits
  localparam int unsigned FIRST_SPARE_REG = 2;
  localparam int unsigned LAST_SPARE_REG  = 2**CFG_IDX_W - 1;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef struct {
    rcvm_pkg::func_e             func;
    logic [ADDR_W-1:0]           load_address;
    logic signed [SAMPLE_W-1:0]  load_left;
    logic signed [SAMPLE_W-1:0]  load_right;
    logic                        interval_start;
    logic [FRAMES_W-1:0]         interval_frames;
    logic [RND_W-1:0]            random_value;
  } mixer_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       clipped_left;
    logic                       clipped_right;
    logic                       chirp_started;
  } mix_frame_t;

  // Shadow of the mixer: chirp store, voice table, registers and the frames owed
  class chirp_mix_scoreboard;
    logic [2*SAMPLE_W-1:0] frame_store [CHIRP_DEPTH];
    bit                    voice_on    [VOICES];
    int unsigned           voice_pos   [VOICES];
    logic [RATE_W-1:0]     rate_q;
    logic [LEN_W-1:0]      length_q;
    mix_frame_t            frames_due [$];
    int unsigned           errors;

    function new();
      foreach (voice_on[i]) begin
        voice_on[i]  = 1'b0;
        voice_pos[i] = 0;
      end
      rate_q   = '0;
      length_q = 13'd1;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        rcvm_pkg::REG_CHIRP_RATE:   rate_q = data[RATE_W-1:0];
        rcvm_pkg::REG_CHIRP_LENGTH: length_q = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned play_length();
      int unsigned n;
      n = length_q;
      if (n == 0) n = 1;
      if (n > CHIRP_DEPTH) n = CHIRP_DEPTH;
      return n;
    endfunction

    // First idle voice, else the one furthest along (lowest index on ties)
    function int unsigned steal_voice();
      int unsigned best;
      best = 0;
      for (int unsigned i = 0; i < VOICES; i++) begin
        if (!voice_on[i]) return i;
        if (voice_pos[i] > voice_pos[best]) best = i;
      end
      return best;
    endfunction

    function mix_frame_t mix_frame(mixer_item_t it);
      mix_frame_t            f;
      longint unsigned       thr;
      longint unsigned       rate_l;
      longint unsigned       frames_l;
      int unsigned           len;
      int unsigned           v;
      int                    sum_l;
      int                    sum_r;
      logic [2*SAMPLE_W-1:0] w;
      f.chirp_started = 1'b0;
      if (it.interval_start) begin
        rate_l   = rate_q;
        frames_l = it.interval_frames;
        thr = (rate_l * frames_l * PROB_SCALE) / (RATE_UNIT * SAMPLE_RATE);
        if (thr > THR_MAX) thr = THR_MAX;
        if (it.random_value < thr) begin
          v = steal_voice();
          voice_on[v]  = 1'b1;
          voice_pos[v] = 0;
          f.chirp_started = 1'b1;
        end
      end
      len   = play_length();
      sum_l = 0;
      sum_r = 0;
      for (int unsigned i = 0; i < VOICES; i++) begin
        if (voice_on[i]) begin
          w = (voice_pos[i] < CHIRP_DEPTH) ? frame_store[voice_pos[i]] : '0;
          sum_l += $signed(w[SAMPLE_W-1:0]);
          sum_r += $signed(w[2*SAMPLE_W-1:SAMPLE_W]);
          voice_pos[i]++;
          // a voice past a shortened length still plays this frame, then stops
          if (voice_pos[i] >= len) begin
            voice_on[i]  = 1'b0;
            voice_pos[i] = 0;
          end
        end
      end
      f.clipped_left  = (sum_l > SAMPLE_MAX) || (sum_l < SAMPLE_MIN);
      f.clipped_right = (sum_r > SAMPLE_MAX) || (sum_r < SAMPLE_MIN);
      f.out_left  = (sum_l > SAMPLE_MAX) ? SAMPLE_MAX :
                    (sum_l < SAMPLE_MIN) ? SAMPLE_MIN : SAMPLE_W'(sum_l);
      f.out_right = (sum_r > SAMPLE_MAX) ? SAMPLE_MAX :
                    (sum_r < SAMPLE_MIN) ? SAMPLE_MIN : SAMPLE_W'(sum_r);
      return f;
    endfunction

    // Called on every accepted input transfer
    function void note_item(mixer_item_t it);
      if (it.func == rcvm_pkg::FUNC_LOAD) begin
        frame_store[it.load_address] = {it.load_right, it.load_left};
      end else begin
        frames_due.push_back(mix_frame(it));
      end
    endfunction

    // Called on every accepted result transfer
    function void check_frame(mix_frame_t got);
      mix_frame_t want;
      if (frames_due.size() == 0) begin
        $error("result transfer with no frame pending");
        errors++;
        return;
      end
      want = frames_due.pop_front();
      if (got.out_left !== want.out_left) begin
        $error("out_left expected %0d, actual %0d", want.out_left, got.out_left);
        errors++;
      end
      if (got.out_right !== want.out_right) begin
        $error("out_right expected %0d, actual %0d", want.out_right, got.out_right);
        errors++;
      end
      if (got.clipped_left !== want.clipped_left) begin
        $error("clipped_left expected %0b, actual %0b", want.clipped_left, got.clipped_left);
        errors++;
      end
      if (got.clipped_right !== want.clipped_right) begin
        $error("clipped_right expected %0b, actual %0b", want.clipped_right,
               got.clipped_right);
        errors++;
      end
      if (got.chirp_started !== want.chirp_started) begin
        $error("chirp_started expected %0b, actual %0b", want.chirp_started,
               got.chirp_started);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return frames_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rcvm_in_if  in_if ();
  rcvm_out_if out_if ();
  rcvm_cfg_if cfg_if ();

  random_chirp_voice_mixer #(
    .VOICES      (VOICES),
    .CHIRP_DEPTH (CHIRP_DEPTH),
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  chirp_mix_scoreboard sb;

  int unsigned send_idle_pct;   // chance per cycle that the sender holds valid low
  int unsigned recv_idle_pct;   // chance per cycle that the receiver drops ready
  bit          rx_hold_req;     // asks the receiver for one long back-pressure burst
  int unsigned rx_hold_left;
  int unsigned cycle_count;

  // Per-phase register settings; lengths of 0 and above the depth are deliberate
  logic [RATE_W-1:0]     phase_rate [NUM_PHASES] = '{
    24'd0, 24'hFFFFFF, 24'd3000, 24'hFFFFFF, 24'd1,
    24'hFFFFFF, 24'd5000, 24'hFFFFFF, 24'd200000
  };
  logic [CFG_DATA_W-1:0] phase_len  [NUM_PHASES] = '{
    24'd1, 24'd64, 24'd17, 24'd4096, 24'd0,
    24'd8191, 24'd2, 24'd33, 24'd100
  };

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Everything the bench drives starts known at time zero
  initial begin
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.func            = rcvm_pkg::FUNC_LOAD;
    in_if.load_address    = '0;
    in_if.load_left       = '0;
    in_if.load_right      = '0;
    in_if.interval_start  = 1'b0;
    in_if.interval_frames = '0;
    in_if.random_value    = '0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    send_idle_pct         = 11;
    recv_idle_pct         = 87;
    rx_hold_req           = 1'b0;
    rx_hold_left          = 0;
    cycle_count           = 0;
    sb                    = new();
  end

  // Run guard: a hang anywhere ends here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: ready changes on the falling edge; a requested hold-off is
  // counted down here so the sender keeps pushing while results back up
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = LONG_HOLD;
    end
    if (rx_hold_left > 0) begin
      out_if.ready = 1'b0;
      rx_hold_left--;
    end else begin
      out_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result transfers are sampled on the rising edge and checked at once
  always @(posedge clk_i) begin
    mix_frame_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.out_left      = out_if.out_left;
      got.out_right     = out_if.out_right;
      got.clipped_left  = out_if.clipped_left;
      got.clipped_right = out_if.clipped_right;
      got.chirp_started = out_if.chirp_started;
      sb.check_frame(got);
    end
  end

  // Offer one item, with random gaps first; entered and left at a falling edge.
  // valid is left high after the transfer so back-to-back items never toggle it.
  task automatic send_item(mixer_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.func            = it.func;
    in_if.load_address    = it.load_address;
    in_if.load_left       = it.load_left;
    in_if.load_right      = it.load_right;
    in_if.interval_start  = it.interval_start;
    in_if.interval_frames = it.interval_frames;
    in_if.random_value    = it.random_value;
    in_if.valid           = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Idle the block before a register write: results all in, loads settled
  task automatic settle();
    in_if.valid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.index = idx;
    cfg_if.data  = data;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // A quarter of samples at full scale so sums clip often
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    return SAMPLE_W'($urandom());
  endfunction

  function automatic mixer_item_t make_play(logic istart, logic [FRAMES_W-1:0] frames,
                                            logic [RND_W-1:0] rnd);
    mixer_item_t it;
    it.func            = rcvm_pkg::FUNC_PLAY;
    it.load_address    = ADDR_W'($urandom());
    it.load_left       = SAMPLE_W'($urandom());
    it.load_right      = SAMPLE_W'($urandom());
    it.interval_start  = istart;
    it.interval_frames = frames;
    it.random_value    = rnd;
    return it;
  endfunction

  function automatic mixer_item_t make_load(logic [ADDR_W-1:0] addr,
                                            logic signed [SAMPLE_W-1:0] left,
                                            logic signed [SAMPLE_W-1:0] right);
    mixer_item_t it;
    it = make_play(1'($urandom()), FRAMES_W'($urandom()), RND_W'($urandom()));
    it.func         = rcvm_pkg::FUNC_LOAD;
    it.load_address = addr;
    it.load_left    = left;
    it.load_right   = right;
    return it;
  endfunction

  // Mostly plays; loads rewrite the played region or land anywhere in the store.
  // Plays only ever read entries below FILL_DEPTH, all of which are preloaded.
  function automatic mixer_item_t random_item();
    logic [ADDR_W-1:0]   addr;
    logic [FRAMES_W-1:0] frames;
    if ($urandom_range(99) < 20) begin
      addr = ($urandom_range(99) < 70) ? ADDR_W'($urandom_range(FILL_DEPTH - 1))
                                       : ADDR_W'($urandom_range(CHIRP_DEPTH - 1));
      return make_load(addr, pick_sample(), pick_sample());
    end
    // interval lengths past 4096 are legal on the port and used as given
    frames = ($urandom_range(99) < 85) ? FRAMES_W'($urandom_range(4096))
                                       : FRAMES_W'($urandom_range(8191, 4097));
    return make_play(1'($urandom_range(1)), frames, RND_W'($urandom_range(32767)));
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] len_data;
    #0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values: rate 0 means no trigger even at an interval of 4096 frames
    send_item(make_play(1'b1, 13'd4096, 15'd0));
    send_item(make_load(12'd4095, SAMPLE_W'($urandom()), SAMPLE_W'($urandom())));

    // Preload the region that voices will read
    for (int unsigned a = 0; a < FILL_DEPTH; a++) begin
      send_item(make_load(ADDR_W'(a), pick_sample(), pick_sample()));
    end

    settle();
    put_reg(rcvm_pkg::REG_CHIRP_RATE, 24'hFFFFFF);
    put_reg(rcvm_pkg::REG_CHIRP_LENGTH, 24'd16);

    // Full-scale frames at both ends of the store and at the first positions
    send_item(make_load(12'd0, SAMPLE_MIN, SAMPLE_MAX));
    send_item(make_load(12'd4095, SAMPLE_MAX, SAMPLE_MIN));
    send_item(make_load(12'd1, SAMPLE_MAX, SAMPLE_MAX));
    send_item(make_load(12'd2, SAMPLE_MIN, SAMPLE_MIN));
    send_item(make_play(1'b0, 13'd0, 15'd0));          // silence, no interval
    send_item(make_play(1'b1, 13'd0, 15'd0));          // zero frames, zero threshold
    send_item(make_play(1'b1, 13'd8191, 15'd32767));   // capped threshold, top random
    send_item(make_play(1'b1, 13'd1, 15'd16382));      // just under the cap: fires
    send_item(make_play(1'b1, 13'd4096, 15'd16383));   // equal to the cap: no fire
    // Back-to-back triggers fill all voices, then steal the oldest
    repeat (10) send_item(make_play(1'b1, 13'd4096, 15'd0));
    repeat (3) send_item(make_play(1'b0, 13'd4096, 15'd0));

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      // three idling regimes: slow receiver, slow sender, then full speed
      case (p / 3)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      settle();
      if (p == SPARE_PHASE) begin
        put_reg(CFG_IDX_W'($urandom_range(LAST_SPARE_REG, FIRST_SPARE_REG)),
                CFG_DATA_W'($urandom()));
      end
      len_data = phase_len[p];
      if (p == JUNK_PHASE) len_data[CFG_DATA_W-1:LEN_W] = (CFG_DATA_W-LEN_W)'($urandom());
      put_reg(rcvm_pkg::REG_CHIRP_RATE, phase_rate[p]);
      put_reg(rcvm_pkg::REG_CHIRP_LENGTH, len_data);
      if (p == HOLD_PHASE) rx_hold_req = 1'b1;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
          in_if.valid = 1'b0;
          wait_drained();
        end
        send_item(random_item());
      end
    end

    in_if.valid = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
